@@ hw/rtl/brb_pkg.sv @@
// Package for the byte ring buffer: opcode and status codes, and the
// per-word result record passed from the control block to the output stage.
// No dependencies.
package brb_pkg;

	localparam logic [1:0] OP_PUSH    = 2'd0;
	localparam logic [1:0] OP_POP_OLD = 2'd1;
	localparam logic [1:0] OP_POP_NEW = 2'd2;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	localparam int unsigned DATA_W  = 8;
	localparam int unsigned S_TDATA_W = 16;
	localparam int unsigned M_TDATA_W = 16;

	typedef struct packed {
		logic       pop_ok;
		logic [1:0] status;
		logic       is_empty;
		logic       is_full;
	} res_t;

endpackage

@@ hw/rtl/brb_ctrl.sv @@
// Pointer and flag control of the byte ring buffer: decodes one word per cycle while
// accept is high, updates the pointers and flags and drives the storage access.
// Depends on brb_pkg.
module brb_ctrl #(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [1:0]          opcode,
	output logic                mem_we,
	output logic                mem_re,
	output logic [AW-1:0]       mem_addr,
	output brb_pkg::res_t       res
);

	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	logic [AW-1:0] wp_q, rp_q;
	logic          full_q, empty_q;
	logic [AW-1:0] wp_d, rp_d, wp_next, wp_prev, rp_next;
	logic          full_d, empty_d;

	assign wp_next = (wp_q == LAST) ? '0 : wp_q + AW'(1);
	assign wp_prev = (wp_q == '0) ? LAST : wp_q - AW'(1);
	assign rp_next = (rp_q == LAST) ? '0 : rp_q + AW'(1);

	always_comb begin
		wp_d       = wp_q;
		rp_d       = rp_q;
		full_d     = full_q;
		empty_d    = empty_q;
		mem_we     = 1'b0;
		mem_re     = 1'b0;
		mem_addr   = wp_q;
		res.pop_ok = 1'b0;
		res.status = brb_pkg::ST_DONE;
		unique case (opcode)
			brb_pkg::OP_PUSH: begin
				if (full_q) begin
					res.status = brb_pkg::ST_FULL;
				end else begin
					mem_we  = 1'b1;
					wp_d    = wp_next;
					empty_d = 1'b0;
					full_d  = (wp_next == rp_q);
				end
			end
			brb_pkg::OP_POP_OLD: begin
				mem_addr = rp_q;
				if (empty_q) begin
					res.status = brb_pkg::ST_EMPTY;
				end else begin
					mem_re     = 1'b1;
					res.pop_ok = 1'b1;
					rp_d       = rp_next;
					full_d     = 1'b0;
					empty_d    = (wp_q == rp_next);
				end
			end
			brb_pkg::OP_POP_NEW: begin
				mem_addr = wp_prev;
				if (empty_q) begin
					res.status = brb_pkg::ST_EMPTY;
				end else begin
					mem_re     = 1'b1;
					res.pop_ok = 1'b1;
					wp_d       = wp_prev;
					full_d     = 1'b0;
					empty_d    = (wp_prev == rp_q);
				end
			end
			default: begin
			end
		endcase
		mem_we       = mem_we & accept;
		mem_re       = mem_re & accept;
		res.is_empty = empty_d;
		res.is_full  = full_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			full_q  <= 1'b0;
			empty_q <= 1'b1;
		end else if (accept) begin
			wp_q    <= wp_d;
			rp_q    <= rp_d;
			full_q  <= full_d;
			empty_q <= empty_d;
		end
	end

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(full_q && empty_q))
		else $error("Buffer flagged full and empty at once.");

	a_full_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		full_q |-> (wp_q == rp_q))
		else $error("Full flag set with pointers apart.");

	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		empty_q |-> (wp_q == rp_q))
		else $error("Empty flag set with pointers apart.");

	a_no_access_refused: assert property (@(posedge clk) disable iff (!arst_n)
		(res.status != brb_pkg::ST_DONE) |-> !(mem_we || mem_re))
		else $error("Storage accessed for a refused word.");

endmodule

@@ hw/rtl/brb_mem.sv @@
// Byte storage of the ring buffer: one shared address port, synchronous
// write and registered read. No dependencies.
module brb_mem #(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	parameter int unsigned DW = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic          re,
	input  logic [AW-1:0] addr,
	input  logic [DW-1:0] wdata,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ hw/rtl/byte_ring_buffer_two_ended_pop.sv @@
// The result word appears on m_tdata in the cycle after its input word is accepted.
// Throughput: one word per cycle; s_tready is high while the output register is empty
// or being drained, so the output-side m_tready sets the rate.
// Reset clears the pointers and the full flag and sets the empty flag; storage is
// not cleared and is only read at entries written before.
module byte_ring_buffer_two_ended_pop #(
	parameter int unsigned DEPTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [brb_pkg::S_TDATA_W-1:0] s_tdata,  // opcode[1:0], data_in[9:2], zero fill above.
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [brb_pkg::M_TDATA_W-1:0] m_tdata   // data_out[7:0], status[9:8],
	                                                // is_empty[10], is_full[11].
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic                           accept;
	logic                           mem_we, mem_re;
	logic [AW-1:0]                  mem_addr;
	logic [brb_pkg::DATA_W-1:0]     rdata;
	brb_pkg::res_t                  res;
	brb_pkg::res_t                  res_s1;
	logic                           valid_s1;

	assign s_tready = !valid_s1 || m_tready;
	assign accept   = s_tvalid && s_tready;

	brb_ctrl #(.DEPTH(DEPTH), .AW(AW)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.opcode   (s_tdata[1:0]),
		.mem_we   (mem_we),
		.mem_re   (mem_re),
		.mem_addr (mem_addr),
		.res      (res)
	);

	brb_mem #(.DEPTH(DEPTH), .AW(AW), .DW(brb_pkg::DATA_W)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.re    (mem_re),
		.addr  (mem_addr),
		.wdata (s_tdata[9:2]),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res;
		end
	end

	assign m_tvalid = valid_s1;
	assign m_tdata  = {4'b0000, res_s1.is_full, res_s1.is_empty, res_s1.status,
		res_s1.pop_ok ? rdata : 8'h00};

endmodule

@@ tb/byte_ring_buffer_two_ended_pop_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for byte_ring_buffer_two_ended_pop: directed and random push,
// pop-oldest and pop-newest words are checked against a ring buffer predictor.
// Depends on brb_pkg and the byte_ring_buffer_two_ended_pop RTL.
module byte_ring_buffer_two_ended_pop_test;

	localparam int RING_DEPTH = 16;
	localparam int MAX_GAP = 12;
	localparam int RANDOM_OPS = 550;
	localparam int CYCLE_LIMIT = 200000;
	localparam logic [1:0] OP_NOP = 2'd3;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] data_in;
	} ring_op_t;

	typedef struct packed {
		logic [7:0] data_out;
		logic [1:0] status;
		logic       is_empty;
		logic       is_full;
	} ring_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;

	ring_op_t     ops_to_send[$];
	ring_result_t ring_results_due[$];

	logic [7:0] ring_mem [RING_DEPTH];
	logic [3:0] wr_ptr = '0;
	logic [3:0] rd_ptr = '0;
	logic       ring_full = 1'b0;
	logic       ring_empty = 1'b1;

	int mismatches = 0;
	int results_seen = 0;
	int cycles = 0;
	int n_push_ok = 0;
	int n_pop_old = 0;
	int n_pop_new = 0;
	int n_full_refused = 0;
	int n_empty_refused = 0;
	int n_nop = 0;

	int       in_gap = 0;
	int       in_calm = 0;
	int       out_stall = 0;
	int       out_calm = 0;
	ring_op_t taken_op;
	ring_result_t seen, due;

	byte_ring_buffer_two_ended_pop #(
		.DEPTH(RING_DEPTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always #5 clk = ~clk;

	function automatic logic [3:0] ptr_next(input logic [3:0] p);
		return (p == RING_DEPTH - 1) ? 4'd0 : p + 4'd1;
	endfunction

	function automatic logic [3:0] ptr_prev(input logic [3:0] p);
		return (p == 0) ? 4'(RING_DEPTH - 1) : p - 4'd1;
	endfunction

	function automatic ring_result_t ring_apply(input ring_op_t w);
		ring_result_t r;
		r = '0;
		r.status = brb_pkg::ST_DONE;
		case (w.opcode)
			brb_pkg::OP_PUSH: begin
				if (ring_full) begin
					r.status = brb_pkg::ST_FULL;
					n_full_refused++;
				end else begin
					ring_mem[wr_ptr] = w.data_in;
					wr_ptr = ptr_next(wr_ptr);
					ring_empty = 1'b0;
					ring_full = (wr_ptr == rd_ptr);
					n_push_ok++;
				end
			end
			brb_pkg::OP_POP_OLD: begin
				if (ring_empty) begin
					r.status = brb_pkg::ST_EMPTY;
					n_empty_refused++;
				end else begin
					r.data_out = ring_mem[rd_ptr];
					rd_ptr = ptr_next(rd_ptr);
					ring_full = 1'b0;
					ring_empty = (wr_ptr == rd_ptr);
					n_pop_old++;
				end
			end
			brb_pkg::OP_POP_NEW: begin
				if (ring_empty) begin
					r.status = brb_pkg::ST_EMPTY;
					n_empty_refused++;
				end else begin
					wr_ptr = ptr_prev(wr_ptr);
					r.data_out = ring_mem[wr_ptr];
					ring_full = 1'b0;
					ring_empty = (wr_ptr == rd_ptr);
					n_pop_new++;
				end
			end
			default: begin
				n_nop++;
			end
		endcase
		r.is_empty = ring_empty;
		r.is_full = ring_full;
		return r;
	endfunction

	function automatic int draw_wait(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 24) == 0)
			calm = $urandom_range(15, 50);
		return $urandom_range(0, 1) ? 0 : $urandom_range(1, MAX_GAP);
	endfunction

	function automatic void queue_op(input logic [1:0] op, input logic [7:0] d);
		ring_op_t w;
		w.opcode = op;
		w.data_in = d;
		ops_to_send.push_back(w);
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at word %0d: %s", results_seen, msg);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				taken_op.opcode = s_tdata[1:0];
				taken_op.data_in = s_tdata[9:2];
				ring_results_due.push_back(ring_apply(taken_op));
			end
			if (!s_tvalid || s_tready) begin
				if (in_gap > 0) begin
					in_gap--;
					s_tvalid <= 1'b0;
				end else if (ops_to_send.size() > 0) begin
					taken_op = ops_to_send.pop_front();
					s_tdata <= {6'b0, taken_op.data_in, taken_op.opcode};
					s_tvalid <= 1'b1;
					in_gap = draw_wait(in_calm);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				seen = '{data_out: m_tdata[7:0], status: m_tdata[9:8],
					is_empty: m_tdata[10], is_full: m_tdata[11]};
				if (ring_results_due.size() == 0) begin
					report_mismatch($sformatf("unexpected word 0x%04h", m_tdata));
				end else begin
					due = ring_results_due.pop_front();
					if (seen.data_out !== due.data_out)
						report_mismatch($sformatf("data_out 0x%02h, expected 0x%02h",
							seen.data_out, due.data_out));
					if (seen.status !== due.status)
						report_mismatch($sformatf("status %0d, expected %0d",
							seen.status, due.status));
					if (seen.is_empty !== due.is_empty)
						report_mismatch($sformatf("is_empty %b, expected %b",
							seen.is_empty, due.is_empty));
					if (seen.is_full !== due.is_full)
						report_mismatch($sformatf("is_full %b, expected %b",
							seen.is_full, due.is_full));
				end
				results_seen++;
				out_stall = draw_wait(out_calm);
			end
			if (out_stall > 0) begin
				out_stall--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d words outstanding.", cycles,
				ring_results_due.size());
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin : stimulus
		int made;
		int run_len;
		int push_pct;
		int roll;

		// Both pop kinds and the no-op on an empty buffer, then extreme bytes, then a fill to full and a push while full.
		queue_op(brb_pkg::OP_POP_OLD, 8'hFF);
		queue_op(brb_pkg::OP_POP_NEW, 8'h00);
		queue_op(OP_NOP, 8'hFF);
		queue_op(brb_pkg::OP_PUSH, 8'h00);
		queue_op(brb_pkg::OP_PUSH, 8'hFF);
		queue_op(brb_pkg::OP_POP_NEW, 8'h5A);
		queue_op(brb_pkg::OP_POP_OLD, 8'hA5);
		for (int i = 0; i < RING_DEPTH; i++)
			queue_op(brb_pkg::OP_PUSH, (i % 2) ? 8'hAA : 8'h55);
		queue_op(brb_pkg::OP_PUSH, 8'hFF);
		queue_op(OP_NOP, 8'h00);

		made = 0;
		while (made < RANDOM_OPS) begin
			run_len = $urandom_range(4, 36);
			case ($urandom_range(0, 2))
				0: push_pct = 85;
				1: push_pct = 15;
				default: push_pct = 50;
			endcase
			for (int i = 0; i < run_len && made < RANDOM_OPS; i++) begin
				roll = $urandom_range(0, 99);
				if (roll < 3)
					queue_op(OP_NOP, 8'($urandom_range(0, 255)));
				else if (roll < 3 + push_pct)
					queue_op(brb_pkg::OP_PUSH, 8'($urandom_range(0, 255)));
				else
					queue_op($urandom_range(0, 1) ? brb_pkg::OP_POP_OLD : brb_pkg::OP_POP_NEW,
						8'($urandom_range(0, 255)));
				made++;
			end
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (ops_to_send.size() > 0 || s_tvalid || ring_results_due.size() > 0)
			@(posedge clk);
		repeat (5) @(posedge clk);

		if (ring_results_due.size() != 0)
			report_mismatch($sformatf("%0d words never arrived", ring_results_due.size()));
		$display("Checked %0d words: %0d pushes stored, %0d oldest and %0d newest pops.",
			results_seen, n_push_ok, n_pop_old, n_pop_new);
		$display("Refused: %0d pushes while full, %0d pops while empty; %0d no-ops.",
			n_full_refused, n_empty_refused, n_nop);
		if (mismatches == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
